// ===== rtl/gsr_pkg.sv =====
package gsr_pkg;

	// Default sizing of the pool.
	localparam int SLOT_COUNT_DEF = 16;
	localparam int SLOT_BYTES_DEF = 256;
	localparam int MAX_READ_DEF   = 64;

	localparam logic [15:0] NO_HANDLE = 16'hFFFF;
	localparam logic [7:0]  GEN_SKIP  = 8'hFF;

	// Request opcodes.
	typedef enum logic [2:0] {
		CMD_BEGIN  = 3'd0,
		CMD_WRITE  = 3'd1,
		CMD_COMMIT = 3'd2,
		CMD_ABORT  = 3'd3,
		CMD_READ   = 3'd4,
		CMD_SIZE   = 3'd5,
		CMD_DELETE = 3'd6,
		CMD_CLEAR  = 3'd7
	} cmd_t;

	// Result status codes.
	localparam logic [2:0] STS_OK          = 3'd0;
	localparam logic [2:0] STS_BAD_HANDLE  = 3'd1;
	localparam logic [2:0] STS_WRONG_STATE = 3'd2;
	localparam logic [2:0] STS_FULL        = 3'd3;
	localparam logic [2:0] STS_EMPTY       = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_CHECK,
		S_RESP,
		S_READ
	} fsm_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic decode;
		logic scan_step;
		logic take;
		logic fail;
		logic exec;
		logic load_resp;
		logic read_step;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_begin;
		logic need_check;
		logic scan_free;
		logic scan_end;
		logic burst_go;
		logic burst_last;
		logic can_load;
	} sts_t;

endpackage

// ===== rtl/gsr_ram.sv =====
module gsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/gsr_datapath.sv =====
module gsr_datapath #(
	parameter int SLOT_COUNT = gsr_pkg::SLOT_COUNT_DEF,
	parameter int SLOT_BYTES = gsr_pkg::SLOT_BYTES_DEF,
	parameter int MAX_READ   = gsr_pkg::MAX_READ_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  gsr_pkg::ctl_t ctl,
	output gsr_pkg::sts_t sts,
	input  logic [2:0]    command,
	input  logic [15:0]   handle,
	input  logic [7:0]    data_byte,
	input  logic [11:0]   read_offset,
	input  logic [6:0]    read_length,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [15:0]   handle_out,
	output logic [2:0]    status,
	output logic [7:0]    data_out,
	output logic [12:0]   amount,
	output logic          last,
	output logic [7:0]    free_slots,
	output logic [7:0]    committed_slots,
	output logic [7:0]    writing_slots
);
	import gsr_pkg::*;

	localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int FILL_W = $clog2(SLOT_BYTES + 1);
	localparam int META_W = 1 + 16 + FILL_W;
	localparam int DEPTH  = SLOT_COUNT * SLOT_BYTES;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Latched request.
	cmd_t        cmd_q;
	logic [15:0] handle_q;
	logic [7:0]  byte_q;
	logic [11:0] off_q;
	logic [6:0]  len_q;

	logic [SLOT_COUNT-1:0] valid_q;
	logic [7:0]            free_q, wr_cnt_q, com_cnt_q, gen_q;
	logic [IDX_W-1:0]      scan_q;
	logic [AW-1:0]         base_q, rd_ptr_q;
	logic [6:0]            remain_q;
	logic [15:0]           res_handle_q;
	logic [2:0]            res_status_q;
	logic [12:0]           res_amount_q;

	logic [15:0] ho_q;
	logic [2:0]  st_q;
	logic [7:0]  do_q;
	logic [12:0] am_q;
	logic        last_q, out_valid_q;

	logic [IDX_W-1:0] idx;
	logic             pre_bad, can_load, do_load;
	logic [7:0]       gen_inc, gen_nxt;
	logic [15:0]      new_handle;

	logic [META_W-1:0] meta_rd, meta_wd;
	logic [IDX_W-1:0]  meta_wa;
	logic              meta_we;
	logic              m_commit;
	logic [15:0]       m_handle;
	logic [FILL_W-1:0] m_fill;

	logic              data_we, data_re;
	logic [AW-1:0]     data_wa, data_ra;
	logic [7:0]        data_rd;

	logic [2:0]        ex_status;
	logic [12:0]       ex_amount;
	logic              ex_write, ex_commit, ex_rel_w, ex_rel_c, ex_burst;
	logic [FILL_W-1:0] avail;
	logic [6:0]        len_sat, burst_n;

	assign idx = handle_q[IDX_W-1:0];
	assign pre_bad = (handle_q == 16'd0) || (handle_q == NO_HANDLE)
		|| (handle_q[7:0] >= 8'(SLOT_COUNT)) || !valid_q[idx];

	assign gen_inc    = gen_q + 8'd1;
	assign gen_nxt    = (gen_inc == 8'd0 || gen_inc == GEN_SKIP) ? 8'd1 : gen_inc;
	assign new_handle = {gen_nxt, 8'(scan_q)};

	assign {m_commit, m_handle, m_fill} = meta_rd;

	assign can_load = !out_valid_q || !out_stall;
	assign do_load  = ctl.load_resp || ctl.read_step;

	assign sts.is_begin   = (cmd_q == CMD_BEGIN);
	assign sts.need_check = (cmd_q != CMD_BEGIN) && (cmd_q != CMD_CLEAR)
		&& !(cmd_q == CMD_READ && len_q == 7'd0) && !pre_bad;
	assign sts.scan_free  = !valid_q[scan_q];
	assign sts.scan_end   = (scan_q == IDX_W'(SLOT_COUNT - 1));
	assign sts.burst_go   = ex_burst;
	assign sts.burst_last = (remain_q == 7'd1);
	assign sts.can_load   = can_load;

	// Evaluation of a checked request against the slot's metadata.
	always_comb begin
		ex_status = STS_OK;
		ex_amount = 13'd0;
		ex_write  = 1'b0;
		ex_commit = 1'b0;
		ex_rel_w  = 1'b0;
		ex_rel_c  = 1'b0;
		ex_burst  = 1'b0;
		avail     = m_fill - FILL_W'(off_q);
		len_sat   = (len_q > 7'(MAX_READ)) ? 7'(MAX_READ) : len_q;
		burst_n   = (13'(len_sat) > 13'(avail)) ? 7'(avail) : len_sat;
		if (m_handle != handle_q) begin
			ex_status = STS_BAD_HANDLE;
		end else begin
			case (cmd_q)
				CMD_WRITE, CMD_COMMIT, CMD_ABORT: begin
					if (m_commit) begin
						ex_status = STS_WRONG_STATE;
					end else if (cmd_q == CMD_WRITE) begin
						if (m_fill >= FILL_W'(SLOT_BYTES)) begin
							ex_status = STS_FULL;
						end else begin
							ex_write  = 1'b1;
							ex_amount = 13'd1;
						end
					end else if (cmd_q == CMD_COMMIT) begin
						ex_commit = 1'b1;
					end else begin
						ex_rel_w = 1'b1;
					end
				end
				CMD_READ, CMD_SIZE, CMD_DELETE: begin
					if (!m_commit) begin
						ex_status = STS_WRONG_STATE;
					end else if (cmd_q == CMD_SIZE) begin
						ex_amount = 13'(m_fill);
					end else if (cmd_q == CMD_DELETE) begin
						ex_rel_c = 1'b1;
					end else if (13'(off_q) >= 13'(m_fill)) begin
						ex_status = STS_EMPTY;
					end else begin
						ex_burst  = 1'b1;
						ex_amount = 13'(burst_n);
					end
				end
				default: begin
					ex_status = STS_OK;
				end
			endcase
		end
	end

	// Metadata port: a begin writes a fresh entry, a write or commit updates one.
	always_comb begin
		meta_we = 1'b0;
		meta_wa = idx;
		meta_wd = {1'b0, handle_q, m_fill + FILL_W'(1)};
		if (ctl.take) begin
			meta_we = 1'b1;
			meta_wa = scan_q;
			meta_wd = {1'b0, new_handle, FILL_W'(0)};
		end else if (ctl.exec && ex_write) begin
			meta_we = 1'b1;
		end else if (ctl.exec && ex_commit) begin
			meta_we = 1'b1;
			meta_wd = {1'b1, handle_q, m_fill};
		end
	end

	assign data_we = ctl.exec && ex_write;
	assign data_wa = base_q + AW'(m_fill);
	assign data_re = (ctl.exec && ex_burst) || (ctl.read_step && !sts.burst_last);
	assign data_ra = ctl.exec ? base_q + AW'(off_q) : rd_ptr_q;

	gsr_ram #(.WIDTH(META_W), .DEPTH(SLOT_COUNT), .AW(IDX_W)) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_wa),
		.wdata (meta_wd),
		.re    (ctl.decode),
		.raddr (idx),
		.rdata (meta_rd)
	);

	gsr_ram #(.WIDTH(8), .DEPTH(DEPTH), .AW(AW)) u_data (
		.clk   (clk),
		.we    (data_we),
		.waddr (data_wa),
		.wdata (byte_q),
		.re    (data_re),
		.raddr (data_ra),
		.rdata (data_rd)
	);

	// Slot occupancy, counters and generation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			free_q      <= 8'(SLOT_COUNT);
			wr_cnt_q    <= 8'd0;
			com_cnt_q   <= 8'd0;
			gen_q       <= 8'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.decode && cmd_q == CMD_CLEAR) begin
				valid_q   <= '0;
				free_q    <= 8'(SLOT_COUNT);
				wr_cnt_q  <= 8'd0;
				com_cnt_q <= 8'd0;
			end
			if (ctl.take) begin
				valid_q[scan_q] <= 1'b1;
				free_q          <= free_q - 8'd1;
				wr_cnt_q        <= wr_cnt_q + 8'd1;
				gen_q           <= gen_nxt;
			end
			if (ctl.exec && ex_commit) begin
				wr_cnt_q  <= wr_cnt_q - 8'd1;
				com_cnt_q <= com_cnt_q + 8'd1;
			end
			if (ctl.exec && ex_rel_w) begin
				valid_q[idx] <= 1'b0;
				wr_cnt_q     <= wr_cnt_q - 8'd1;
				free_q       <= free_q + 8'd1;
			end
			if (ctl.exec && ex_rel_c) begin
				valid_q[idx] <= 1'b0;
				com_cnt_q    <= com_cnt_q - 8'd1;
				free_q       <= free_q + 8'd1;
			end
			if (do_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q    <= cmd_t'(command);
			handle_q <= handle;
			byte_q   <= data_byte;
			off_q    <= read_offset;
			len_q    <= read_length;
		end
		if (ctl.decode) begin
			scan_q       <= '0;
			base_q       <= AW'(32'(idx) * SLOT_BYTES);
			res_handle_q <= 16'd0;
			res_amount_q <= 13'd0;
			if (cmd_q == CMD_CLEAR) begin
				res_status_q <= STS_OK;
			end else if (cmd_q == CMD_READ && len_q == 7'd0) begin
				res_status_q <= STS_EMPTY;
			end else begin
				res_status_q <= STS_BAD_HANDLE;
			end
		end
		if (ctl.scan_step) begin
			scan_q <= scan_q + IDX_W'(1);
		end
		if (ctl.take) begin
			res_handle_q <= new_handle;
			res_status_q <= STS_OK;
		end
		if (ctl.fail) begin
			res_handle_q <= NO_HANDLE;
			res_status_q <= STS_FULL;
		end
		if (ctl.exec) begin
			res_status_q <= ex_status;
			res_amount_q <= ex_amount;
			remain_q     <= burst_n;
		end
		if (data_re) begin
			rd_ptr_q <= data_ra + AW'(1);
		end
		if (ctl.read_step) begin
			remain_q <= remain_q - 7'd1;
		end
		if (ctl.load_resp) begin
			ho_q   <= res_handle_q;
			st_q   <= res_status_q;
			do_q   <= 8'd0;
			am_q   <= res_amount_q;
			last_q <= 1'b1;
		end
		if (ctl.read_step) begin
			ho_q   <= 16'd0;
			st_q   <= STS_OK;
			do_q   <= data_rd;
			am_q   <= res_amount_q;
			last_q <= sts.burst_last;
		end
		if (do_load) begin
			free_slots      <= free_q;
			committed_slots <= com_cnt_q;
			writing_slots   <= wr_cnt_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign handle_out = ho_q;
	assign status     = st_q;
	assign data_out   = do_q;
	assign amount     = am_q;
	assign last       = last_q;

endmodule

// ===== rtl/gsr_ctrl.sv =====
module gsr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  gsr_pkg::sts_t sts,
	output gsr_pkg::ctl_t ctl
);
	import gsr_pkg::*;

	fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (sts.is_begin) state_d = S_SCAN;
				else if (sts.need_check) state_d = S_CHECK;
				else state_d = S_RESP;
			end
			S_SCAN: begin
				if (sts.scan_free || sts.scan_end) state_d = S_RESP;
			end
			S_CHECK: begin
				state_d = sts.burst_go ? S_READ : S_RESP;
			end
			S_RESP: begin
				if (sts.can_load) state_d = S_IDLE;
			end
			S_READ: begin
				if (sts.can_load && sts.burst_last) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE:   ctl.accept = in_valid;
			S_DECODE: ctl.decode = 1'b1;
			S_SCAN: begin
				ctl.take      = sts.scan_free;
				ctl.fail      = !sts.scan_free && sts.scan_end;
				ctl.scan_step = !sts.scan_free && !sts.scan_end;
			end
			S_CHECK:  ctl.exec = 1'b1;
			S_RESP:   ctl.load_resp = sts.can_load;
			S_READ:   ctl.read_step = sts.can_load;
			default:  ctl = '0;
		endcase
	end

endmodule

// ===== rtl/generational_slot_record_store.sv =====
// Sequence: a request is accepted, decoded in the next cycle, checked against its slot's metadata where
// needed (a begin scans the slots instead) and its result is then loaded into the output register.
// Throughput: one request at a time; the next is accepted once the result is registered. A read
// burst delivers one byte per cycle from the registered data memory port while out_stall is low.
// Reset (arst_n low) frees every slot, zeroes the counters and sets the generation to one;
// the byte memory needs no clearing pass, since only bytes below a slot's fill are read.
module generational_slot_record_store #(
	parameter int SLOT_COUNT = gsr_pkg::SLOT_COUNT_DEF,
	parameter int SLOT_BYTES = gsr_pkg::SLOT_BYTES_DEF,
	parameter int MAX_READ   = gsr_pkg::MAX_READ_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [15:0] handle,
	input  logic [7:0]  data_byte,
	input  logic [11:0] read_offset,
	input  logic [6:0]  read_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] handle_out,
	output logic [2:0]  status,
	output logic [7:0]  data_out,
	output logic [12:0] amount,
	output logic        last,
	output logic [7:0]  free_slots,
	output logic [7:0]  committed_slots,
	output logic [7:0]  writing_slots
);
	import gsr_pkg::*;

	// The controller sequences each request; the datapath owns the slot
	// metadata, the byte memory, the counters and the output register.
	ctl_t ctl;
	sts_t sts;

	gsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	gsr_datapath #(
		.SLOT_COUNT (SLOT_COUNT),
		.SLOT_BYTES (SLOT_BYTES),
		.MAX_READ   (MAX_READ)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.command         (command),
		.handle          (handle),
		.data_byte       (data_byte),
		.read_offset     (read_offset),
		.read_length     (read_length),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.handle_out      (handle_out),
		.status          (status),
		.data_out        (data_out),
		.amount          (amount),
		.last            (last),
		.free_slots      (free_slots),
		.committed_slots (committed_slots),
		.writing_slots   (writing_slots)
	);

endmodule

// ===== rtl/gsr_checker.sv =====
module gsr_checker #(
	parameter int SLOT_COUNT = gsr_pkg::SLOT_COUNT_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] handle_out,
	input logic [2:0]  status,
	input logic [7:0]  data_out,
	input logic        last,
	input logic [7:0]  free_slots,
	input logic [7:0]  committed_slots,
	input logic [7:0]  writing_slots
);
	import gsr_pkg::*;

	// Every slot is in exactly one state.
	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (10'(free_slots) + 10'(committed_slots) + 10'(writing_slots))
			== 10'(SLOT_COUNT))
		else $error("slot counts do not add up to the pool size");

	// An exhausted pool reports the null handle.
	a_full_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STS_FULL && handle_out != 16'd0) |-> handle_out == NO_HANDLE)
		else $error("pool full without null handle");

	// A failing request gives a single result.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STS_OK) |-> last)
		else $error("error result not marked last");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(data_out) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind generational_slot_record_store gsr_checker #(.SLOT_COUNT(SLOT_COUNT)) u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.handle_out      (handle_out),
	.status          (status),
	.data_out        (data_out),
	.last            (last),
	.free_slots      (free_slots),
	.committed_slots (committed_slots),
	.writing_slots   (writing_slots)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the generational slot record store.
// An initial block builds the whole request list up front. While it does so it runs every request
// through a behavioural model of the pool held in this module. The model's view of live handles
// is what lets the generator aim most requests at real records. The results that each request
// will cause are parked beside it, and they become due only when the block accepts the request.
// A clocked driver offers the requests with random gaps. A clocked monitor takes the results with
// random stalls and compares them, field by field, with the oldest result that is due.
module tb_top;
	import gsr_pkg::*;

	localparam int NSLOT  = SLOT_COUNT_DEF;
	localparam int NBYTE  = SLOT_BYTES_DEF;
	localparam int NREAD  = MAX_READ_DEF;

	typedef enum logic [1:0] {
		ST_FREE,
		ST_WRITING,
		ST_COMMITTED
	} slot_st_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] hdl;
		logic [7:0]  dat;
		logic [11:0] off;
		logic [6:0]  len;
	} store_req_t;

	typedef struct packed {
		logic [15:0] hdl;
		logic [2:0]  sts;
		logic [7:0]  dat;
		logic [12:0] amt;
		logic        lst;
		logic [7:0]  nfree;
		logic [7:0]  ncomm;
		logic [7:0]  nwrit;
	} store_rsp_t;

	logic clk;
	logic arst_n;

	logic        in_valid;
	logic        in_stall;
	logic [2:0]  command;
	logic [15:0] handle;
	logic [7:0]  data_byte;
	logic [11:0] read_offset;
	logic [6:0]  read_length;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] handle_out;
	logic [2:0]  status;
	logic [7:0]  data_out;
	logic [12:0] amount;
	logic        last;
	logic [7:0]  free_slots;
	logic [7:0]  committed_slots;
	logic [7:0]  writing_slots;

	// Model of the pool, advanced as the request list is built.
	slot_st_t    pool_st [NSLOT];
	logic [15:0] pool_hdl [NSLOT];
	int          pool_fill [NSLOT];
	logic [7:0]  pool_mem [NSLOT][NBYTE];
	logic [7:0]  pool_gen;

	// Requests waiting to be offered, with the number of results that each causes.
	store_req_t  req_q[$];
	int          req_nrsp_q[$];
	// Results computed in request order, not yet due.
	store_rsp_t  planned_rsp_q[$];
	// Results due from the block, oldest first.
	store_rsp_t  due_rsp_q[$];

	int          fail_cnt;
	int          accepted_cnt;
	int          in_gap;
	int          out_gap;
	int          cur_nrsp;
	logic        hold_off;

	generational_slot_record_store DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.handle          (handle),
		.data_byte       (data_byte),
		.read_offset     (read_offset),
		.read_length     (read_length),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.handle_out      (handle_out),
		.status          (status),
		.data_out        (data_out),
		.amount          (amount),
		.last            (last),
		.free_slots      (free_slots),
		.committed_slots (committed_slots),
		.writing_slots   (writing_slots)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Mostly short gaps, sometimes longer ones, the odd very long one. Every fourth stretch of
	// 64 accepted requests runs with no gaps at all.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if ((accepted_cnt / 64) % 4 == 1)
			return 0;
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Builds one result, with the per-state slot counts as they stand after the request.
	function automatic void record_rsp(logic [15:0] h, logic [2:0] s, logic [7:0] d,
			logic [12:0] a, logic l);
		store_rsp_t rsp;
		int nf;
		int nc;
		int nw;
		nf = 0;
		nc = 0;
		nw = 0;
		for (int i = 0; i < NSLOT; i++) begin
			if (pool_st[i] == ST_FREE)
				nf++;
			else if (pool_st[i] == ST_COMMITTED)
				nc++;
			else
				nw++;
		end
		rsp.hdl   = h;
		rsp.sts   = s;
		rsp.dat   = d;
		rsp.amt   = a;
		rsp.lst   = l;
		rsp.nfree = 8'(nf);
		rsp.ncomm = 8'(nc);
		rsp.nwrit = 8'(nw);
		planned_rsp_q.push_back(rsp);
	endfunction

	function automatic void pool_reset();
		for (int i = 0; i < NSLOT; i++) begin
			pool_st[i]   = ST_FREE;
			pool_hdl[i]  = NO_HANDLE;
			pool_fill[i] = 0;
			for (int j = 0; j < NBYTE; j++)
				pool_mem[i][j] = 8'h00;
		end
	endfunction

	// Slot index that a handle refers to, or -1 when the handle is malformed or stale.
	function automatic int find_slot(logic [15:0] h);
		int idx;
		idx = h[7:0];
		if (h == NO_HANDLE || h == 16'h0000 || idx >= NSLOT)
			return -1;
		if (pool_hdl[idx] != h)
			return -1;
		return idx;
	endfunction

	// Advances the pool model by one request and records the results that it causes.
	function automatic void pool_apply(store_req_t r);
		int idx;
		int n;
		int avail;
		if (r.cmd == CMD_BEGIN) begin
			for (int i = 0; i < NSLOT; i++) begin
				if (pool_st[i] == ST_FREE) begin
					// The generation never takes the values reserved for no handle.
					pool_gen = pool_gen + 8'd1;
					if (pool_gen == 8'h00 || pool_gen == GEN_SKIP)
						pool_gen = 8'd1;
					pool_st[i]   = ST_WRITING;
					pool_hdl[i]  = {pool_gen, 8'(i)};
					pool_fill[i] = 0;
					record_rsp(pool_hdl[i], STS_OK, 8'h00, 13'd0, 1'b1);
					return;
				end
			end
			record_rsp(NO_HANDLE, STS_FULL, 8'h00, 13'd0, 1'b1);
			return;
		end
		if (r.cmd == CMD_CLEAR) begin
			pool_reset();
			record_rsp(16'h0000, STS_OK, 8'h00, 13'd0, 1'b1);
			return;
		end
		// A read of length zero is refused before the handle is looked at.
		if (r.cmd == CMD_READ && r.len == 7'd0) begin
			record_rsp(16'h0000, STS_EMPTY, 8'h00, 13'd0, 1'b1);
			return;
		end
		idx = find_slot(r.hdl);
		if (idx < 0) begin
			record_rsp(16'h0000, STS_BAD_HANDLE, 8'h00, 13'd0, 1'b1);
			return;
		end
		case (r.cmd)
			CMD_WRITE, CMD_COMMIT, CMD_ABORT: begin
				if (pool_st[idx] != ST_WRITING) begin
					record_rsp(16'h0000, STS_WRONG_STATE, 8'h00, 13'd0, 1'b1);
				end else if (r.cmd == CMD_WRITE) begin
					if (pool_fill[idx] >= NBYTE) begin
						record_rsp(16'h0000, STS_FULL, 8'h00, 13'd0, 1'b1);
					end else begin
						pool_mem[idx][pool_fill[idx]] = r.dat;
						pool_fill[idx]++;
						record_rsp(16'h0000, STS_OK, 8'h00, 13'd1, 1'b1);
					end
				end else begin
					if (r.cmd == CMD_COMMIT) begin
						pool_st[idx] = ST_COMMITTED;
					end else begin
						pool_st[idx]   = ST_FREE;
						pool_hdl[idx]  = NO_HANDLE;
						pool_fill[idx] = 0;
					end
					record_rsp(16'h0000, STS_OK, 8'h00, 13'd0, 1'b1);
				end
			end
			default: begin
				if (pool_st[idx] != ST_COMMITTED) begin
					record_rsp(16'h0000, STS_WRONG_STATE, 8'h00, 13'd0, 1'b1);
				end else if (r.cmd == CMD_SIZE) begin
					record_rsp(16'h0000, STS_OK, 8'h00, 13'(pool_fill[idx]), 1'b1);
				end else if (r.cmd == CMD_DELETE) begin
					pool_st[idx]   = ST_FREE;
					pool_hdl[idx]  = NO_HANDLE;
					pool_fill[idx] = 0;
					record_rsp(16'h0000, STS_OK, 8'h00, 13'd0, 1'b1);
				end else if (r.off >= pool_fill[idx]) begin
					record_rsp(16'h0000, STS_EMPTY, 8'h00, 13'd0, 1'b1);
				end else begin
					// The burst is cut at the read limit and at the end of the data.
					avail = pool_fill[idx] - r.off;
					n = (r.len > NREAD) ? NREAD : r.len;
					if (n > avail)
						n = avail;
					for (int i = 0; i < n; i++)
						record_rsp(16'h0000, STS_OK, pool_mem[idx][r.off + i], 13'(n),
							i == n - 1);
				end
			end
		endcase
	endfunction

	function automatic void add_req(cmd_t c, logic [15:0] h, logic [7:0] d,
			logic [11:0] o, logic [6:0] l);
		store_req_t r;
		int base_cnt;
		r.cmd = c;
		r.hdl = h;
		r.dat = d;
		r.off = o;
		r.len = l;
		base_cnt = planned_rsp_q.size();
		pool_apply(r);
		req_q.push_back(r);
		req_nrsp_q.push_back(planned_rsp_q.size() - base_cnt);
	endfunction

	// Handle of a random slot in the given state; a junk handle when there is none.
	function automatic logic [15:0] pick_handle(slot_st_t want);
		int hits[$];
		for (int i = 0; i < NSLOT; i++)
			if (pool_st[i] == want)
				hits.push_back(i);
		if (hits.size() == 0)
			return {8'($urandom), 8'($urandom_range(0, NSLOT - 1))};
		return pool_hdl[hits[$urandom_range(0, hits.size() - 1)]];
	endfunction

	function automatic int count_state(slot_st_t want);
		int n;
		n = 0;
		for (int i = 0; i < NSLOT; i++)
			if (pool_st[i] == want)
				n++;
		return n;
	endfunction

	function automatic logic [15:0] last_new_handle();
		return planned_rsp_q[planned_rsp_q.size() - 1].hdl;
	endfunction

	// Builds the request list.
	initial begin
		logic [15:0] h0;
		logic [15:0] h1;
		int r;
		pool_reset();
		pool_gen = 8'd1;

		// Directed part: a small record read every way, then bad handles and wrong states.
		add_req(CMD_BEGIN, 16'h0000, 8'h00, 12'd0, 7'd0);
		h0 = last_new_handle();
		add_req(CMD_WRITE, h0, 8'h00, 12'd0, 7'd0);
		add_req(CMD_WRITE, h0, 8'hFF, 12'd0, 7'd0);
		add_req(CMD_WRITE, h0, 8'hA5, 12'd0, 7'd0);
		add_req(CMD_COMMIT, h0, 8'h00, 12'd0, 7'd0);
		add_req(CMD_READ, h0, 8'h00, 12'd0, 7'd0);
		add_req(CMD_READ, h0, 8'h00, 12'd0, 7'd127);
		add_req(CMD_READ, h0, 8'h00, 12'd4095, 7'd1);
		add_req(CMD_READ, h0, 8'h00, 12'd1, 7'd64);
		add_req(CMD_SIZE, h0, 8'h00, 12'd0, 7'd0);
		add_req(CMD_WRITE, h0, 8'h11, 12'd0, 7'd0);
		add_req(CMD_WRITE, 16'h0000, 8'h22, 12'd0, 7'd0);
		add_req(CMD_COMMIT, 16'hFFFF, 8'h00, 12'd0, 7'd0);
		add_req(CMD_READ, 16'h02C8, 8'h00, 12'd0, 7'd4);
		add_req(CMD_BEGIN, 16'h0000, 8'h00, 12'd0, 7'd0);
		h1 = last_new_handle();
		add_req(CMD_READ, h1, 8'h00, 12'd0, 7'd4);
		add_req(CMD_SIZE, h1, 8'h00, 12'd0, 7'd0);
		add_req(CMD_ABORT, h1, 8'h00, 12'd0, 7'd0);
		add_req(CMD_ABORT, h1, 8'h00, 12'd0, 7'd0);
		add_req(CMD_DELETE, h0, 8'h00, 12'd0, 7'd0);
		add_req(CMD_DELETE, h0, 8'h00, 12'd0, 7'd0);
		add_req(CMD_CLEAR, 16'h0000, 8'h00, 12'd0, 7'd0);
		add_req(CMD_BEGIN, 16'h0000, 8'h00, 12'd0, 7'd0);
		h0 = last_new_handle();
		add_req(CMD_COMMIT, h0, 8'h00, 12'd0, 7'd0);
		add_req(CMD_READ, h0, 8'h00, 12'd0, 7'd8);

		// Exhaust the pool, then start again from empty.
		for (int i = 0; i < NSLOT + 1; i++)
			add_req(CMD_BEGIN, 16'h0000, 8'h00, 12'd0, 7'd0);
		add_req(CMD_CLEAR, 16'h0000, 8'h00, 12'd0, 7'd0);

		// Fill one record to capacity and past it, then read it back in long bursts.
		add_req(CMD_BEGIN, 16'h0000, 8'h00, 12'd0, 7'd0);
		h0 = last_new_handle();
		for (int i = 0; i < NBYTE + 2; i++)
			add_req(CMD_WRITE, h0, 8'($urandom), 12'd0, 7'd0);
		add_req(CMD_COMMIT, h0, 8'h00, 12'd0, 7'd0);
		add_req(CMD_SIZE, h0, 8'h00, 12'd0, 7'd0);
		add_req(CMD_READ, h0, 8'h00, 12'd0, 7'd64);
		add_req(CMD_READ, h0, 8'h00, 12'd200, 7'd100);
		add_req(CMD_READ, h0, 8'h00, 12'd255, 7'd3);
		add_req(CMD_READ, h0, 8'h00, 12'd256, 7'd3);

		// Random part: mostly well-formed record traffic, with some noise.
		for (int i = 0; i < 150; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8 || (r < 45 && count_state(ST_WRITING) == 0)) begin
				add_req(CMD_BEGIN, 16'($urandom), 8'($urandom), 12'($urandom), 7'($urandom));
			end else if (r < 45) begin
				add_req(CMD_WRITE, pick_handle(ST_WRITING), 8'($urandom), 12'd0, 7'd0);
			end else if (r < 52) begin
				add_req(CMD_COMMIT, pick_handle(ST_WRITING), 8'h00, 12'd0, 7'd0);
			end else if (r < 55) begin
				add_req(CMD_ABORT, pick_handle(ST_WRITING), 8'h00, 12'd0, 7'd0);
			end else if (r < 72) begin
				add_req(CMD_READ, pick_handle(ST_COMMITTED), 8'h00,
					12'($urandom_range(0, 24)),
					($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 70)));
			end else if (r < 78) begin
				add_req(CMD_SIZE, pick_handle(ST_COMMITTED), 8'h00, 12'd0, 7'd0);
			end else if (r < 83) begin
				add_req(CMD_DELETE, pick_handle(ST_COMMITTED), 8'h00, 12'd0, 7'd0);
			end else if (r == 83) begin
				add_req(CMD_CLEAR, 16'h0000, 8'h00, 12'd0, 7'd0);
			end else begin
				add_req(cmd_t'($urandom_range(1, 6)),
					($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 15)),
					8'($urandom), 12'($urandom), 7'($urandom));
			end
		end
	end

	// Reset is applied once, at the start of the run.
	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Request driver. On acceptance the results of that request become due.
	always @(posedge clk or negedge arst_n) begin
		store_req_t r;
		if (!arst_n) begin
			in_valid     <= 1'b0;
			command      <= 3'd0;
			handle       <= 16'h0000;
			data_byte    <= 8'h00;
			read_offset  <= 12'd0;
			read_length  <= 7'd0;
			in_gap       = 0;
			cur_nrsp     = 0;
			accepted_cnt = 0;
		end else begin
			if (in_valid && !in_stall) begin
				for (int i = 0; i < cur_nrsp; i++)
					due_rsp_q.push_back(planned_rsp_q.pop_front());
				accepted_cnt++;
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0 || req_q.size() == 0) begin
					if (in_gap > 0)
						in_gap--;
					in_valid <= 1'b0;
				end else begin
					r = req_q.pop_front();
					cur_nrsp = req_nrsp_q.pop_front();
					in_valid    <= 1'b1;
					command     <= r.cmd;
					handle      <= r.hdl;
					data_byte   <= r.dat;
					read_offset <= r.off;
					read_length <= r.len;
					in_gap = pick_gap();
				end
			end
		end
	end

	// Once the run is under way the receiver holds off for a long stretch, so that results
	// back up into the block and it stalls further requests.
	initial begin
		hold_off = 1'b0;
		wait (accepted_cnt >= 120);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Result monitor with random stalls.
	always @(posedge clk or negedge arst_n) begin
		store_rsp_t exp_rsp;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap   = 0;
			fail_cnt  = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_rsp_q.size() == 0) begin
					$error("result with nothing due: handle_out %0h status %0d", handle_out,
						status);
					fail_cnt++;
				end else begin
					exp_rsp = due_rsp_q.pop_front();
					if (handle_out !== exp_rsp.hdl) begin
						$error("handle_out: expected %0h, got %0h", exp_rsp.hdl, handle_out);
						fail_cnt++;
					end
					if (status !== exp_rsp.sts) begin
						$error("status: expected %0d, got %0d", exp_rsp.sts, status);
						fail_cnt++;
					end
					if (data_out !== exp_rsp.dat) begin
						$error("data_out: expected %0h, got %0h", exp_rsp.dat, data_out);
						fail_cnt++;
					end
					if (amount !== exp_rsp.amt) begin
						$error("amount: expected %0d, got %0d", exp_rsp.amt, amount);
						fail_cnt++;
					end
					if (last !== exp_rsp.lst) begin
						$error("last: expected %0b, got %0b", exp_rsp.lst, last);
						fail_cnt++;
					end
					if (free_slots !== exp_rsp.nfree) begin
						$error("free_slots: expected %0d, got %0d", exp_rsp.nfree, free_slots);
						fail_cnt++;
					end
					if (committed_slots !== exp_rsp.ncomm) begin
						$error("committed_slots: expected %0d, got %0d", exp_rsp.ncomm,
							committed_slots);
						fail_cnt++;
					end
					if (writing_slots !== exp_rsp.nwrit) begin
						$error("writing_slots: expected %0d, got %0d", exp_rsp.nwrit,
							writing_slots);
						fail_cnt++;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else begin
				out_gap = pick_gap();
				out_stall <= hold_off;
			end
		end
	end

	// End of run: every request taken, every result in, then a short drain for stray results.
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		wait (req_q.size() == 0 && !in_valid);
		wait (due_rsp_q.size() == 0);
		repeat (40) @(posedge clk);
		if (fail_cnt == 0 && due_rsp_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#100ms;
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== generational_slot_record_store.f =====
rtl/gsr_pkg.sv
rtl/gsr_ram.sv
rtl/gsr_datapath.sv
rtl/gsr_ctrl.sv
rtl/generational_slot_record_store.sv
rtl/gsr_checker.sv
tb/tb_top.sv
